FILE: rtl/fbrd_pkg.sv
// ----------------------------------------------------------------------------
// fbrd_pkg
// Types and codes shared by the page framebuffer rectangle draw unit.
// ----------------------------------------------------------------------------
package fbrd_pkg;

    localparam int PAGE_ROWS = 8;
    localparam int COORD_W   = 18;   // signed walk coordinates, covers x + 2*255

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PIXEL = 2'd1,
        OP_RECT  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // One decoded command as it sits in the queue
    typedef struct packed {
        op_t                op;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         rect_width;
        logic [7:0]         rect_height;
        logic               fill_or_on;
        logic [4:0]         chunk_index;
    } cmd_t;

    // Back end status toward the front end
    typedef struct packed {
        logic init_done;
        logic pop;
    } back_stat_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CLEAR,
        B_SETUP,
        B_PIX_RD,
        B_PIX_WR,
        B_RD_ISSUE,
        B_RD_LOAD
    } back_state_t;

endpackage

FILE: rtl/fbrd_ram.sv
// ----------------------------------------------------------------------------
// fbrd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fbrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: rtl/fbrd_front.sv
// ----------------------------------------------------------------------------
// fbrd_front
// Accepts items, unpacks them into commands and holds them in a 2-entry queue.
// ----------------------------------------------------------------------------
module fbrd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,
    input  logic [1:0]            s_tuser,
    input  fbrd_pkg::back_stat_t  stat,
    output logic                  q_valid,
    output fbrd_pkg::cmd_t        q_head
);
    import fbrd_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    cmd_t       in_cmd;

    always_comb begin
        in_cmd.op          = op_t'(s_tuser);
        in_cmd.pos_x       = s_tdata[15:0];
        in_cmd.pos_y       = s_tdata[31:16];
        in_cmd.rect_width  = s_tdata[39:32];
        in_cmd.rect_height = s_tdata[47:40];
        in_cmd.fill_or_on  = s_tdata[48];
        in_cmd.chunk_index = s_tdata[53:49];
    end

    // no items while the store is still being cleared after reset
    assign s_tready = stat.init_done && (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_head   = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = stat.pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, stat.pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end
endmodule

FILE: rtl/fbrd_back.sv
// ----------------------------------------------------------------------------
// fbrd_back
// Executes commands: clear sweep, pixel read-modify-write walk, chunk readout.
// ----------------------------------------------------------------------------
module fbrd_back #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64,
    parameter int CHUNK_BYTES  = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  fbrd_pkg::cmd_t        q_head,
    output fbrd_pkg::back_stat_t  stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);
    import fbrd_pkg::*;

    localparam int PAGE_COUNT  = (PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int KW          = $clog2(CHUNK_BYTES + 1);
    localparam int RAW         = $clog2(32 * CHUNK_BYTES + STORE_BYTES) + 1;
    localparam logic [AW:0]    PW_C   = (AW+1)'(PANEL_WIDTH);
    localparam logic [AW-1:0]  LAST_A = AW'(STORE_BYTES - 1);

    back_state_t state_reg, state_next;

    cmd_t        cmd_reg;
    logic        init_done_reg, init_done_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [1:0]  pass_reg, pass_next;
    logic signed [COORD_W-1:0] ox_reg, oy_reg, ox_next, oy_next;
    logic [7:0]  ew_reg, eh_reg, ew_next, eh_next;
    logic [7:0]  ci_reg, cj_reg, ci_next, cj_next;
    logic        val_reg, val_next;
    logic [AW-1:0] paddr_reg, paddr_next;
    logic [7:0]  mask_reg, mask_next;
    logic [KW-1:0] k_reg, k_next;
    logic        inrng_reg, inrng_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;

    // setup values for the current pass
    logic signed [COORD_W-1:0] sx, sy, px_w, py_h;
    logic [7:0]  s_ew, s_eh;
    logic        s_val, s_skip;
    logic [1:0]  last_pass;

    // pixel under the walk
    logic signed [COORD_W-1:0] col, row;
    logic        on_panel;
    logic [AW:0] addr_full;
    logic        step_last_ci, step_last_cj, pass_done;

    // chunk read address
    logic [RAW-1:0] rd_a;
    logic           k_last, load_out;

    // RAM ports
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    fbrd_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        px_w      = COORD_W'(cmd_reg.pos_x) + COORD_W'($signed({1'b0, cmd_reg.rect_width}))
                    - COORD_W'(1);
        py_h      = COORD_W'(cmd_reg.pos_y) + COORD_W'($signed({1'b0, cmd_reg.rect_height}))
                    - COORD_W'(1);
        sx        = COORD_W'(cmd_reg.pos_x);
        sy        = COORD_W'(cmd_reg.pos_y);
        s_ew      = cmd_reg.rect_width;
        s_eh      = cmd_reg.rect_height;
        s_val     = 1'b1;
        last_pass = 2'd0;
        if (cmd_reg.op == OP_PIXEL) begin
            s_ew  = 8'd1;
            s_eh  = 8'd1;
            s_val = cmd_reg.fill_or_on;
        end else if (!cmd_reg.fill_or_on) begin
            // outline: top, bottom, left, right edges
            last_pass = 2'd3;
            case (pass_reg)
                2'd0: begin
                    s_eh = 8'd1;
                end
                2'd1: begin
                    sy   = py_h;
                    s_eh = 8'd1;
                end
                2'd2: begin
                    s_ew = 8'd1;
                end
                default: begin
                    sx   = px_w;
                    s_ew = 8'd1;
                end
            endcase
        end
        s_skip = (s_ew == 8'd0) || (s_eh == 8'd0);
    end

    always_comb begin
        col       = ox_reg + COORD_W'(ci_reg);
        row       = oy_reg + COORD_W'(cj_reg);
        on_panel  = (col >= 0) && (col < COORD_W'(PANEL_WIDTH)) &&
                    (row >= 0) && (row < COORD_W'(PANEL_HEIGHT));
        addr_full = col[AW:0] + row[AW+3:3] * PW_C;
        step_last_ci = (ci_reg == ew_reg - 8'd1);
        step_last_cj = (cj_reg == eh_reg - 8'd1);
        pass_done    = step_last_ci && step_last_cj;
        rd_a      = RAW'(cmd_reg.chunk_index) * RAW'(CHUNK_BYTES) + RAW'(k_reg);
        k_last    = (k_reg == KW'(CHUNK_BYTES - 1));
        load_out  = !out_valid_reg || m_tready;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    case (q_head.op)
                        OP_CLEAR: state_next = B_CLEAR;
                        OP_READ:  state_next = B_RD_ISSUE;
                        default:  state_next = B_SETUP;
                    endcase
                end
            end
            B_CLEAR: begin
                if (clr_reg == LAST_A) state_next = B_IDLE;
            end
            B_SETUP: begin
                if (!s_skip)                    state_next = B_PIX_RD;
                else if (pass_reg == last_pass) state_next = B_IDLE;
            end
            B_PIX_RD, B_PIX_WR: begin
                if (state_reg == B_PIX_RD && on_panel) begin
                    state_next = B_PIX_WR;
                end else if (pass_done) begin
                    state_next = (pass_reg == last_pass) ? B_IDLE : B_SETUP;
                end else begin
                    state_next = B_PIX_RD;
                end
            end
            B_RD_ISSUE: state_next = B_RD_LOAD;
            B_RD_LOAD: begin
                if (load_out) state_next = k_last ? B_IDLE : B_RD_ISSUE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        init_done_next = init_done_reg;
        clr_next       = clr_reg;
        pass_next      = pass_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        ew_next        = ew_reg;
        eh_next        = eh_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        val_next       = val_reg;
        paddr_next     = paddr_reg;
        mask_next      = mask_reg;
        k_next         = k_reg;
        inrng_next     = inrng_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        stat.init_done = init_done_reg;
        stat.pop       = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = clr_reg;
        ram_wdata      = 8'd0;
        ram_raddr      = addr_full[AW-1:0];
        case (state_reg)
            B_IDLE: begin
                stat.pop  = q_valid;
                clr_next  = '0;
                pass_next = 2'd0;
                k_next    = '0;
            end
            B_CLEAR: begin
                ram_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_A) init_done_next = 1'b1;
            end
            B_SETUP: begin
                ox_next   = sx;
                oy_next   = sy;
                ew_next   = s_ew;
                eh_next   = s_eh;
                val_next  = s_val;
                ci_next   = 8'd0;
                cj_next   = 8'd0;
                if (s_skip) pass_next = pass_reg + 2'd1;
            end
            B_PIX_RD, B_PIX_WR: begin
                if (state_reg == B_PIX_RD) begin
                    ram_re     = on_panel;
                    paddr_next = addr_full[AW-1:0];
                    mask_next  = 8'd1 << row[2:0];
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = paddr_reg;
                    ram_wdata = val_reg ? (ram_rdata | mask_reg) : (ram_rdata & ~mask_reg);
                end
                if (state_reg == B_PIX_WR || !on_panel) begin
                    if (step_last_ci) begin
                        ci_next = 8'd0;
                        if (step_last_cj) pass_next = pass_reg + 2'd1;
                        else              cj_next   = cj_reg + 8'd1;
                    end else begin
                        ci_next = ci_reg + 8'd1;
                    end
                end
            end
            B_RD_ISSUE: begin
                ram_re     = 1'b1;
                ram_raddr  = rd_a[AW-1:0];
                inrng_next = (rd_a < RAW'(STORE_BYTES));
            end
            B_RD_LOAD: begin
                if (load_out) begin
                    out_valid_next = 1'b1;
                    out_data_next  = inrng_reg ? ram_rdata : 8'd0;
                    out_last_next  = k_last;
                    k_next         = k_reg + KW'(1);
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_CLEAR;
            init_done_reg <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_done_reg <= init_done_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
        if (state_reg == B_IDLE && q_valid) begin
            cmd_reg <= q_head;
        end
        pass_reg     <= pass_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        ew_reg       <= ew_next;
        eh_reg       <= eh_next;
        ci_reg       <= ci_next;
        cj_reg       <= cj_next;
        val_reg      <= val_next;
        paddr_reg    <= paddr_next;
        mask_reg     <= mask_next;
        k_reg        <= k_next;
        inrng_reg    <= inrng_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end
endmodule

FILE: rtl/page_framebuffer_rect_draw_unit.sv
// ----------------------------------------------------------------------------
// page_framebuffer_rect_draw_unit
// Monochrome page-layout framebuffer: clear, pixel write, rectangle draw,
// chunk readout.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | contents
//  s_      | in  | s_tvalid/s_tready  | tuser operation, tdata coordinates etc.
//  m_      | out | m_tvalid/m_tready  | tdata pixel_byte, tlast last_of_chunk
//
//  After reset a clearing pass writes zeros over the whole store of
//  PANEL_WIDTH * ceil(PANEL_HEIGHT/8) bytes (1024 by default), one byte per
//  cycle; no item is accepted until it ends. A clear item takes the same sweep.
//  Pixel write steps: queue pop, setup, read, write back; the RAM access is
//  skipped when clipped. Rectangle: each on-panel pixel is read and written
//  back (read-modify-write through the registered RAM read); a clipped pixel
//  skips the RAM access. Chunk read: each byte is issued, then loaded into the
//  output register, stalled by m_tready, before the next byte is issued.
//  A 2-entry queue lets items arrive while the back end is busy.
// ----------------------------------------------------------------------------
module page_framebuffer_rect_draw_unit #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64,
    parameter int CHUNK_BYTES  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_x[15:0], pos_y[31:16], rect_width[39:32], rect_height[47:40],
    // fill_or_on[48], chunk_index[53:49], zero pad [55:54]
    input  logic [55:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_byte[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);
    import fbrd_pkg::*;

    back_stat_t stat;
    logic       q_valid;
    cmd_t       q_head;

    fbrd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .q_valid  (q_valid),
        .q_head   (q_head)
    );

    fbrd_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .CHUNK_BYTES  (CHUNK_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );
endmodule

FILE: dv/page_framebuffer_rect_draw_unit_tb.sv
// ----------------------------------------------------------------------------
// page_framebuffer_rect_draw_unit_tb
// Drives clear, pixel, rectangle and chunk-read items into the framebuffer
// unit with random idling on both sides, mirrors the store in a local copy
// and checks every read-out byte and its last flag in order.
// ----------------------------------------------------------------------------
module page_framebuffer_rect_draw_unit_tb;
    import fbrd_pkg::*;

    localparam int PANEL_W     = 128;
    localparam int PANEL_H     = 64;
    localparam int CHUNK_LEN   = 32;
    localparam int PAGE_CNT    = (PANEL_H + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_LEN   = PANEL_W * PAGE_CNT;
    localparam int RANDOM_ITEMS = 470;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_CLEAR;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    page_framebuffer_rect_draw_unit #(
        .PANEL_WIDTH (PANEL_W),
        .PANEL_HEIGHT(PANEL_H),
        .CHUNK_BYTES (CHUNK_LEN)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Expected read-out byte and its last flag
    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       last_of_chunk;
    } byte_exp_t;

    // One row of the directed table; has_exp marks a hand-typed first byte
    typedef struct {
        cmd_t       cmd;
        logic       has_exp;
        logic [7:0] exp_byte;
    } dir_row_t;

    logic [7:0] shadow_fb [STORE_LEN];
    byte_exp_t  pending_bytes [$];
    int         error_count = 0;
    int         hand_checks [$];   // index of the read-out byte to hand-check
    logic [7:0] hand_values [$];
    int         send_idle_pct = 12;
    int         recv_idle_pct = 67;
    bit         hold_recv = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic void plot(input int col, input int row, input bit on);
        int idx;
        if (col < 0 || col >= PANEL_W || row < 0 || row >= PANEL_H) return;
        idx = col + (row / PAGE_ROWS) * PANEL_W;
        shadow_fb[idx][row % PAGE_ROWS] = on;
    endfunction

    // Updates the shadow store and queues the bytes an item produces
    function automatic void predict_item(input cmd_t c);
        int x, y, w, h, a;
        x = int'(c.pos_x); y = int'(c.pos_y);
        w = int'(c.rect_width); h = int'(c.rect_height);
        case (c.op)
            OP_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = '0;
            OP_PIXEL: plot(x, y, c.fill_or_on);
            OP_RECT: begin
                if (c.fill_or_on) begin
                    for (int i = x; i < x + w; i++)
                        for (int j = y; j < y + h; j++) plot(i, j, 1'b1);
                end else begin
                    // outline: a zero width or a zero height (not both) still yields two lines
                    for (int i = x; i < x + w; i++) begin
                        plot(i, y, 1'b1);
                        plot(i, y + h - 1, 1'b1);
                    end
                    for (int j = y; j < y + h; j++) begin
                        plot(x, j, 1'b1);
                        plot(x + w - 1, j, 1'b1);
                    end
                end
            end
            default: begin
                for (int k = 0; k < CHUNK_LEN; k++) begin
                    a = c.chunk_index * CHUNK_LEN + k;
                    pending_bytes.push_back({(a < STORE_LEN) ? shadow_fb[a] : 8'h00,
                                             k == CHUNK_LEN - 1});
                end
            end
        endcase
    endfunction

    function automatic cmd_t make_cmd(input op_t op, input int x, input int y,
                                      input int w, input int h, input int f,
                                      input int ch);
        cmd_t c;
        c.op = op; c.pos_x = 16'(x); c.pos_y = 16'(y);
        c.rect_width = 8'(w); c.rect_height = 8'(h);
        c.fill_or_on = f[0]; c.chunk_index = 5'(ch);
        return c;
    endfunction

    // Random item: mostly on-panel work, some far-off coordinates
    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   sel;
        sel = $urandom_range(0, 99);
        c.pos_x = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 140) - 6);
        c.pos_y = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 74) - 6);
        c.rect_width  = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
        c.rect_height = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
        c.fill_or_on  = 1'($urandom_range(0, 1));
        c.chunk_index = 5'($urandom);
        if (sel < 2)       c.op = OP_CLEAR;
        else if (sel < 45) c.op = OP_PIXEL;
        else if (sel < 70) c.op = OP_RECT;
        else               c.op = OP_READ;
        return c;
    endfunction

    // Offer one item, with random leading idles, and wait for acceptance.
    // tvalid stays high after acceptance; the next call replaces the item or
    // drops tvalid, and the end of the stimulus drops it.
    task automatic send_item(input cmd_t c);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.op;
        s_tdata  <= {2'b00, c.chunk_index, c.fill_or_on, c.rect_height, c.rect_width,
                     c.pos_y, c.pos_x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(c);
    endtask

    // Receiver readiness, redrawn every cycle
    always @(posedge aclk) begin
        if (!aresetn || hold_recv) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result checker
    int seen_bytes = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("unexpected item", int'(m_tdata), 0);
            end else begin
                byte_exp_t e;
                e = pending_bytes.pop_front();
                if (hand_checks.size() > 0 && hand_checks[0] == seen_bytes) begin
                    void'(hand_checks.pop_front());
                    if (m_tdata !== hand_values[0])
                        report_mismatch("directed byte", int'(m_tdata), int'(hand_values[0]));
                    void'(hand_values.pop_front());
                end
                if (m_tdata !== e.pixel_byte)
                    report_mismatch("pixel_byte", int'(m_tdata), int'(e.pixel_byte));
                if (m_tlast !== e.last_of_chunk)
                    report_mismatch("last_of_chunk", int'(m_tlast), int'(e.last_of_chunk));
            end
            seen_bytes++;
        end
    end

    // Queue index of the first byte the next read will produce
    int queued_total = 0;

    task automatic run_random(input int count);
        cmd_t c;
        for (int n = 0; n < count; n++) begin
            c = rand_cmd();
            send_item(c);
        end
    endtask

    dir_row_t dir_table [$];

    initial begin
        cmd_t c;
        foreach (shadow_fb[i]) shadow_fb[i] = '0;

        // Directed rows: read after reset, extremes, clipping, zero sizes
        dir_table = '{
            '{make_cmd(OP_READ, 0, 0, 0, 0, 0, 0), 1'b1, 8'h00},
            '{make_cmd(OP_PIXEL, 0, 0, 0, 0, 1, 0), 1'b0, 8'h00},
            '{make_cmd(OP_PIXEL, 127, 63, 0, 0, 1, 0), 1'b0, 8'h00},
            '{make_cmd(OP_READ, 0, 0, 0, 0, 0, 0), 1'b1, 8'h01},
            '{make_cmd(OP_PIXEL, -32768, 32767, 255, 255, 1, 31), 1'b0, 8'h00},
            '{make_cmd(OP_PIXEL, 32767, -32768, 0, 0, 1, 0), 1'b0, 8'h00},
            '{make_cmd(OP_PIXEL, 128, 64, 0, 0, 1, 0), 1'b0, 8'h00},
            '{make_cmd(OP_PIXEL, 0, 0, 0, 0, 0, 0), 1'b0, 8'h00},
            '{make_cmd(OP_READ, 0, 0, 0, 0, 0, 31), 1'b1, 8'h00},
            '{make_cmd(OP_RECT, 10, 3, 0, 5, 0, 0), 1'b0, 8'h00},
            '{make_cmd(OP_RECT, 20, 20, 6, 0, 0, 0), 1'b0, 8'h00},
            '{make_cmd(OP_RECT, 30, 30, 0, 0, 0, 0), 1'b0, 8'h00},
            '{make_cmd(OP_RECT, 40, 40, 0, 7, 1, 0), 1'b0, 8'h00},
            '{make_cmd(OP_RECT, 50, 8, 9, 9, 0, 0), 1'b0, 8'h00},
            '{make_cmd(OP_RECT, -3, -3, 10, 10, 1, 0), 1'b0, 8'h00},
            '{make_cmd(OP_RECT, 120, 56, 255, 255, 1, 0), 1'b0, 8'h00},
            '{make_cmd(OP_READ, 0, 0, 0, 0, 0, 5), 1'b0, 8'h00},
            '{make_cmd(OP_READ, 0, 0, 0, 0, 0, 31), 1'b0, 8'h00},
            '{make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1'b0, 8'h00},
            '{make_cmd(OP_READ, 0, 0, 0, 0, 0, 31), 1'b1, 8'h00},
            '{make_cmd(OP_READ, -1, -1, 255, 255, 1, 16), 1'b1, 8'h00}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_table[i]) begin
            if (dir_table[i].has_exp) begin
                hand_checks.push_back(queued_total);
                hand_values.push_back(dir_table[i].exp_byte);
            end
            if (dir_table[i].cmd.op == OP_READ) queued_total += CHUNK_LEN;
            send_item(dir_table[i].cmd);
        end

        // Long receiver hold-off while reads keep coming: fills the queue
        fork
            begin
                hold_recv = 1'b1;
                repeat (600) @(posedge aclk);
                hold_recv = 1'b0;
            end
            begin
                for (int n = 0; n < 6; n++) begin
                    c = make_cmd(OP_READ, 0, 0, 0, 0, 0, $urandom);
                    send_item(c);
                end
            end
        join

        run_random(RANDOM_ITEMS / 3);
        send_idle_pct = 67; recv_idle_pct = 12;
        run_random(RANDOM_ITEMS / 3);
        send_idle_pct = 0;  recv_idle_pct = 0;
        run_random(RANDOM_ITEMS / 3);
        s_tvalid <= 1'b0;

        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        if (error_count == 0 && pending_bytes.size() == 0) begin
            $display("page_framebuffer_rect_draw_unit test passed");
        end else begin
            $display("page_framebuffer_rect_draw_unit test failed");
        end
        $finish;
    end

    // Watchdog: sized for every item being a full 255x255 rectangle walk
    initial begin
        #800000000;
        $display("page_framebuffer_rect_draw_unit test failed");
        $finish;
    end

endmodule
